// ===== rtl/fwht_pkg.sv =====
// Shared types and constants for the four-way hash table.
`default_nettype none
package fwht_pkg;
  localparam logic [1:0] CMD_PROBE = 2'd0;
  localparam logic [1:0] CMD_STORE = 2'd1;
  localparam logic [1:0] CMD_NEWSRCH = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WAYS = 4;
  localparam logic signed [15:0] SCORE_MAX = 16'sd32000;
  localparam logic signed [15:0] SCORE_MIN = -16'sd32000;
  localparam logic signed [7:0] DEPTH_MAX = 8'sd125;
  localparam logic signed [7:0] DEPTH_MIN = -8'sd1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [63:0] key;
    logic [7:0] depth;
    logic [15:0] score;
    logic [15:0] eval;
    logic [1:0] bound_flag;
    logic [20:0] best_move;
  } item_t;

  typedef struct packed {
    logic hit;
    logic [20:0] found_move;
    logic [15:0] found_score;
    logic [15:0] found_eval;
    logic [7:0] found_depth;
    logic [1:0] found_flag;
    logic written;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/fwht_front.sv =====
// Input stage and two-entry queue that decouples acceptance from execution.
`default_nettype none
module fwht_front (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  output logic in_ready,
  input wire fwht_pkg::item_t in_item,
  output logic q_valid,
  input wire logic q_take,
  output fwht_pkg::item_t q_item
);
  fwht_pkg::item_t buf_r [2];
  logic rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_take;
  assign q_item = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_item;
    end
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/fwht_back.sv =====
// Table memory, clear sweep, probe and store execution, and result register.
`default_nettype none
module fwht_back #(
  parameter int CLUSTER_INDEX_BITS = 10
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic [1:0] exact_code,
  input wire logic q_valid,
  output logic q_take,
  input wire fwht_pkg::item_t q_item,
  output logic out_valid,
  input wire logic out_ready,
  output fwht_pkg::result_t out_res
);
  localparam int NCL = 1 << CLUSTER_INDEX_BITS;
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [511:0] mem [NCL];
  logic [511:0] rd_r;
  logic [1:0] state_r, state_nxt;
  logic [CLUSTER_INDEX_BITS-1:0] clr_r;
  logic [1:0] gen_r;
  fwht_pkg::item_t it_r;
  logic ov_r;
  fwht_pkg::result_t res_r, res_nxt;
  logic wr_en;
  logic [511:0] wr_data;
  logic [CLUSTER_INDEX_BITS-1:0] wr_addr, idx;

  assign idx = q_item.key[CLUSTER_INDEX_BITS-1:0];
  assign q_take = (state_r == ST_IDLE) && q_valid && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_res = res_r;

  function automatic logic signed [15:0] sat16(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > fwht_pkg::SCORE_MAX) r = fwht_pkg::SCORE_MAX;
    if (v < fwht_pkg::SCORE_MIN) r = fwht_pkg::SCORE_MIN;
    return r;
  endfunction

  always_comb begin
    logic [63:0] d, k, nd;
    logic [20:0] mv;
    logic signed [7:0] dp, sd;
    logic signed [9:0] val, worst, dp3;
    logic [1:0] pick, age;
    logic done, skip;
    logic signed [15:0] sc, ev;
    res_nxt = '0;
    wr_en = 1'b0;
    wr_data = rd_r;
    wr_addr = it_r.key[CLUSTER_INDEX_BITS-1:0];
    pick = 2'd0;
    done = 1'b0;
    skip = 1'b0;
    mv = it_r.best_move;
    worst = 10'sh1ff;
    dp3 = 10'(signed'(it_r.depth)) + 10'sd3;
    for (int i = 0; i < fwht_pkg::WAYS; i++) begin
      d = rd_r[i*128 +: 64];
      k = rd_r[i*128+64 +: 64];
      sd = signed'({1'b0, d[59:53]}) - 8'sd1;
      age = gen_r - d[63:62];
      val = 10'(sd) - 10'(signed'({1'b0, age, 3'b0}));
      if (!done) begin
        if (it_r.cmd == fwht_pkg::CMD_PROBE) begin
          if (d != 64'd0 && (k ^ d) == it_r.key) begin
            done = 1'b1;
            res_nxt.hit = 1'b1;
            res_nxt.found_move = d[20:0];
            res_nxt.found_score = {~d[36], d[35:21]};
            res_nxt.found_eval = {~d[52], d[51:37]};
            res_nxt.found_depth = sd;
            res_nxt.found_flag = d[61:60];
          end
        end else if (d == 64'd0) begin
          done = 1'b1;
          pick = 2'(i);
        end else if ((k ^ d) == it_r.key) begin
          done = 1'b1;
          pick = 2'(i);
          if (10'(sd) > dp3 && d[63:62] == gen_r && it_r.bound_flag != exact_code)
            skip = 1'b1;
          if (it_r.best_move == 21'd0) mv = d[20:0];
        end else if (val < worst) begin
          worst = val;
          pick = 2'(i);
        end
      end
    end
    dp = signed'(it_r.depth);
    if (dp > fwht_pkg::DEPTH_MAX) dp = fwht_pkg::DEPTH_MAX;
    if (dp < fwht_pkg::DEPTH_MIN) dp = fwht_pkg::DEPTH_MIN;
    sc = sat16(signed'(it_r.score));
    ev = sat16(signed'(it_r.eval));
    nd = {gen_r, it_r.bound_flag, 7'(dp + 8'sd1), ~ev[15], ev[14:0], ~sc[15], sc[14:0], mv};
    if (it_r.cmd == fwht_pkg::CMD_STORE && !skip) begin
      wr_en = 1'b1;
      res_nxt.written = 1'b1;
      wr_data[pick*128 +: 128] = {it_r.key ^ nd, nd};
    end
    if (state_r == ST_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (state_r != ST_EXEC) begin
      wr_en = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == CLUSTER_INDEX_BITS'(NCL - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (q_take && q_item.cmd != fwht_pkg::CMD_UNUSED &&
                   q_item.cmd != fwht_pkg::CMD_NEWSRCH)
        state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_take) rd_r <= mem[idx];
    if (wr_en) mem[wr_addr] <= wr_data;
    if (q_take) it_r <= q_item;
    if (state_r == ST_EXEC) res_r <= res_nxt;
    else if (q_take) res_r <= '0;
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      gen_r <= 2'd0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (q_take && q_item.cmd == fwht_pkg::CMD_NEWSRCH) gen_r <= gen_r + 2'd1;
      if (state_r == ST_EXEC || (q_take && (q_item.cmd == fwht_pkg::CMD_UNUSED ||
          q_item.cmd == fwht_pkg::CMD_NEWSRCH)))
        ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/four_way_hash_table_depth_age_replace.sv =====
// Top level of the four-way set-associative hash table.
//
// The in_ channel takes one transaction per command: probe, store or new search.
// The out_ channel returns exactly one transaction per command, in order.
// A probe or store reads a whole four-way cluster into a register when it is
// taken, then compares and writes back in the execution state. Reads and
// writes never share a cycle, so the memory needs a single port. A new search
// or an unused command is finished when it is taken. The result of a probe or
// store passes through the queue, the read register and the execution state
// before out_tvalid rises; a new search or an unused command skips execution.
// A two-entry queue keeps accepting while the execution unit works.
// After reset the table is cleared one cluster per cycle, all 2**CLUSTER_INDEX_BITS
// clusters, while commands wait in the queue. Configuration writes are taken
// at any time. When the receiver stalls, the result register holds and
// execution pauses; the queue fills and then in_tready drops.
`default_nettype none
module four_way_hash_table_depth_age_replace #(
  parameter int CLUSTER_INDEX_BITS = 10
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_wdata,
  input wire logic in_tvalid,
  output logic in_tready,
  // cmd, key, depth, score, eval, bound_flag, best_move; 7 unused bits on top.
  input wire logic [135:0] in_tdata,
  output logic out_tvalid,
  input wire logic out_tready,
  // hit, found_move, found_score, found_eval, found_depth, found_flag, written.
  output logic [71:0] out_tdata
);
  logic [1:0] exact_r;
  fwht_pkg::item_t in_item, q_item;
  fwht_pkg::result_t res;
  logic q_valid, q_take;

  assign in_item.cmd = in_tdata[1:0];
  assign in_item.key = in_tdata[65:2];
  assign in_item.depth = in_tdata[73:66];
  assign in_item.score = in_tdata[89:74];
  assign in_item.eval = in_tdata[105:90];
  assign in_item.bound_flag = in_tdata[107:106];
  assign in_item.best_move = in_tdata[128:108];

  assign out_tdata = {7'd0, res.written, res.found_flag, res.found_depth, res.found_eval,
                      res.found_score, res.found_move, res.hit};

  always_ff @(posedge clk) begin
    if (!rst_n) exact_r <= 2'd3;
    else if (cfg_we) exact_r <= cfg_wdata;
  end

  fwht_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_item,
    .q_valid, .q_take, .q_item
  );

  fwht_back #(.CLUSTER_INDEX_BITS(CLUSTER_INDEX_BITS)) u_back (
    .clk, .rst_n, .exact_code(exact_r), .q_valid, .q_take, .q_item,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[63:1] == '0)
    else $error("miss with payload");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[64]))
    else $error("hit and written together");
endmodule
`default_nettype wire
